FILE: src/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside of reset.
`define ASSERT_CLK(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/sspt_pkg.sv
package sspt_pkg;

    // Default number of store entries, one cell per entry.
    localparam int CAPACITY_DEF = 1024;

    // Field widths fixed by the interface.
    localparam int STRENGTH_W = 16;
    localparam int KEY_W      = STRENGTH_W + 1;
    localparam int THRESH_W   = 32;
    localparam int COUNT_W    = 11;
    localparam int OP_W       = 2;

    // Key that no stored strength can reach.
    localparam logic [KEY_W-1:0] KEY_NONE = {1'b1, {STRENGTH_W{1'b0}}};

    // Input selector codes.
    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_QUERY  = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    // Kind of beat moving down the cell chain.
    typedef enum logic [1:0] {
        TK_NONE   = 2'd0,
        TK_INSERT = 2'd1,
        TK_QUERY  = 2'd2
    } tok_kind_t;

    // Token handed from cell to cell. For an insert, val carries the
    // strength being placed; for a query, the smallest strength that
    // reaches the threshold.
    typedef struct packed {
        tok_kind_t        kind;
        logic [KEY_W-1:0] val;
        logic             ovf;
    } tok_t;

    // Divider status seen by the head controller.
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // Head controller states.
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_DIV  = 1'b1
    } state_t;

endpackage

FILE: src/sspt_cell.sv
module sspt_cell #(
    parameter int CW = 11
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,
    input  sspt_pkg::tok_t tok_in,
    input  logic [CW-1:0] rem_in,
    input  logic [CW-1:0] acc_in,
    output sspt_pkg::tok_t tok_out,
    output logic [CW-1:0] rem_out,
    output logic [CW-1:0] acc_out
);
    import sspt_pkg::*;

    logic [STRENGTH_W-1:0] entry_reg, entry_next;
    tok_t                  tok_reg, tok_next;
    logic [CW-1:0]         rem_reg, rem_next;
    logic [CW-1:0]         acc_reg, acc_next;
    logic                  live;

    // The remaining count tells whether this cell holds a stored entry:
    // it is nonzero for every cell below the fill level.
    always_comb
    begin
        tok_next   = tok_in;
        rem_next   = rem_in;
        acc_next   = acc_in;
        entry_next = entry_reg;
        live       = (rem_in != '0);
        if (live)
        begin
            rem_next = rem_in - 1'b1;
        end
        case (tok_in.kind)
            TK_INSERT:
            begin
                if (!live)
                begin
                    // First free cell: the carried strength settles here.
                    entry_next    = tok_in.val[STRENGTH_W-1:0];
                    tok_next.kind = TK_NONE;
                end
                else if ({1'b0, entry_reg} > tok_in.val)
                begin
                    // Swap so the larger strength moves on toward the tail.
                    entry_next   = tok_in.val[STRENGTH_W-1:0];
                    tok_next.val = {1'b0, entry_reg};
                end
            end
            TK_QUERY:
            begin
                if (live && ({1'b0, entry_reg} >= tok_in.val))
                begin
                    acc_next = acc_in + 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Token control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '{kind: TK_NONE, val: '0, ovf: 1'b0};
        end
        else if (adv)
        begin
            tok_reg <= tok_next;
        end
    end

    // Stored entry and token payload.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            entry_reg <= entry_next;
            rem_reg   <= rem_next;
            acc_reg   <= acc_next;
        end
    end

    assign tok_out = tok_reg;
    assign rem_out = rem_reg;
    assign acc_out = acc_reg;

endmodule

FILE: src/sspt_div.sv
module sspt_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [sspt_pkg::THRESH_W-1:0] threshold,
    input  logic [sspt_pkg::STRENGTH_W-1:0] strength,
    output sspt_pkg::div_stat_t           stat,
    output logic [sspt_pkg::KEY_W-1:0]    key
);
    import sspt_pkg::*;

    localparam int STEP_W = $clog2(THRESH_W);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [STRENGTH_W-1:0] rem_reg, rem_next;
    logic [THRESH_W-1:0]   dvd_reg, dvd_next;
    logic [THRESH_W-1:0]   quo_reg, quo_next;
    logic [STRENGTH_W-1:0] dsr_reg, dsr_next;
    logic [KEY_W-1:0]      key_reg, key_next;
    logic [KEY_W-1:0]      trial;
    logic [KEY_W-1:0]      diff;
    logic                  ge;

    // One restoring step per cycle on (threshold - 1) / strength. The key
    // is the ceiling of threshold / strength, saturated at one past the
    // largest strength.
    always_comb
    begin
        trial     = {rem_reg, dvd_reg[THRESH_W-1]};
        diff      = trial - {1'b0, dsr_reg};
        ge        = (trial >= {1'b0, dsr_reg});
        busy_next = busy_reg;
        done_next = done_reg;
        step_next = step_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        key_next  = key_reg;
        if (start)
        begin
            busy_next = 1'b0;
            done_next = 1'b1;
            if (threshold == '0)
            begin
                key_next = '0;
            end
            else if (strength == '0)
            begin
                key_next = KEY_NONE;
            end
            else
            begin
                busy_next = 1'b1;
                done_next = 1'b0;
                step_next = '1;
                rem_next  = '0;
                dvd_next  = threshold - 1'b1;
                quo_next  = '0;
                dsr_next  = strength;
            end
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? diff[STRENGTH_W-1:0] : trial[STRENGTH_W-1:0];
            dvd_next  = {dvd_reg[THRESH_W-2:0], 1'b0};
            quo_next  = {quo_reg[THRESH_W-2:0], ge};
            step_next = step_reg - 1'b1;
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                if (quo_next[THRESH_W-1:STRENGTH_W] != '0)
                begin
                    key_next = KEY_NONE;
                end
                else
                begin
                    key_next = {1'b0, quo_next[STRENGTH_W-1:0]} + 1'b1;
                end
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // Datapath.
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
        key_reg <= key_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign key       = key_reg;

endmodule

FILE: src/sorted_store_product_threshold_count_unit.sv
// Channel  Dir  Signals                       Contents
// s        in   s_tvalid s_tready s_tdata     strength; s_tuser carries op
// m        out  m_tvalid m_tready m_tdata     pair_count, overflowed
// cfg      in   cfg_valid cfg_ready cfg_data  success_threshold
//
// Insert and clear beats are taken one per cycle while the output is not
// stalled. A query beat holds the input while the radix-2 divider turns the
// threshold into a strength key; with a zero threshold or a zero strength
// the key is known at once. The query token then crosses the cell chain
// and the output register, which offers its result.
// Reset is asynchronous and active low; no clearing pass is needed.
// A stalled output freezes the whole chain and the input until taken.
module sorted_store_product_threshold_count_unit #(
    parameter int CAPACITY = sspt_pkg::CAPACITY_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input beat.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] strength
    input  logic [1:0]  s_tuser,   // [1:0] op
    // Result beat.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [10:0] pair_count, [11] overflowed, [15:12] zero
    // Threshold register write.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);
    import sspt_pkg::*;
`include "assert_macros.svh"

    localparam int CW = $clog2(CAPACITY + 1);

    state_t                state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic                  ovf_reg, ovf_next;
    logic [THRESH_W-1:0]   thresh_reg;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [15:0]           m_tdata_reg;
    logic                  adv;
    logic                  in_fire;
    logic                  div_start;
    div_stat_t             div_stat;
    logic [KEY_W-1:0]      div_key;
    op_t                   op;
    tok_t                  head_tok;
    tok_t                  tok_w [CAPACITY+1];
    logic [CW-1:0]         rem_w [CAPACITY+1];
    logic [CW-1:0]         acc_w [CAPACITY+1];
    tok_t                  tail_tok;
    logic [COUNT_W-1:0]    pair_count;

    // The chain moves whenever the output register can take a beat.
    assign adv       = !m_tvalid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) && adv;
    assign in_fire   = s_tvalid && s_tready;
    assign op        = op_t'(s_tuser);
    assign cfg_ready = 1'b1;

    // Threshold register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            thresh_reg <= cfg_data;
        end
    end

    // Head controller: next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && (op == OP_QUERY))
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_stat.done && adv)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Head controller: outputs, fill count and sticky flag.
    always_comb
    begin
        head_tok   = '{kind: TK_NONE, val: '0, ovf: 1'b0};
        div_start  = 1'b0;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (op)
                        OP_INSERT:
                        begin
                            if (count_reg == CW'(CAPACITY))
                            begin
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                head_tok.kind = TK_INSERT;
                                head_tok.val  = {1'b0, s_tdata};
                                count_next    = count_reg + 1'b1;
                            end
                        end
                        OP_QUERY:
                        begin
                            div_start = 1'b1;
                        end
                        OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_DIV:
            begin
                if (div_stat.done && adv)
                begin
                    head_tok.kind = TK_QUERY;
                    head_tok.val  = div_key;
                    head_tok.ovf  = ovf_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Head control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    // Threshold to key conversion.
    sspt_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .threshold (thresh_reg),
        .strength  (s_tdata),
        .stat      (div_stat),
        .key       (div_key)
    );

    // Cell chain, one cell per store entry.
    assign tok_w[0] = head_tok;
    assign rem_w[0] = count_reg;
    assign acc_w[0] = '0;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        sspt_cell #(
            .CW (CW)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .tok_in  (tok_w[i]),
            .rem_in  (rem_w[i]),
            .acc_in  (acc_w[i]),
            .tok_out (tok_w[i+1]),
            .rem_out (rem_w[i+1]),
            .acc_out (acc_w[i+1])
        );
    end

    assign tail_tok   = tok_w[CAPACITY];
    assign pair_count = COUNT_W'(acc_w[CAPACITY]);

    // Output register fed by query beats leaving the chain.
    assign m_tvalid_next = (tail_tok.kind == TK_QUERY);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (adv)
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_tdata_reg <= 16'({tail_tok.ovf, pair_count});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `ASSERT_CLK(a_count_bound, count_reg <= CW'(CAPACITY), "fill count above capacity")
    `ASSERT_CLK(a_ovf_sticky, ovf_reg |=> ovf_reg, "overflow flag dropped")
    `ASSERT_CLK(a_query_key_ready, (head_tok.kind == TK_QUERY) |-> div_stat.done, "early query")
    `ASSERT_CLK(a_div_active, (state_reg == ST_DIV) |-> (div_stat.busy || div_stat.done), "div idle")
    `ASSERT_CLK(a_insert_settles, tail_tok.kind != TK_INSERT, "insert beat ran off the chain")
    `ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !m_tvalid, "result valid during reset")

endmodule
